FILE: hw/rtl/text_console_with_pointer_core_macros.svh
// Assertion macros for the text console core.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef TEXT_CONSOLE_WITH_POINTER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WITH_POINTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TCP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCP_ASSERT(name, clk, rst_n, prop, msg)
`define TCP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/tcp_pkg.sv
// Shared types, request codes and constants of the text console core.
// No dependencies.
package tcp_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [1:0] REQ_PRINT = 2'd0;
  localparam logic [1:0] REQ_MOVE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_PRINT     = 3'd1;
  localparam logic [2:0] OP_NEWLINE   = 3'd2;
  localparam logic [2:0] OP_MOVE      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;
  localparam logic [2:0] OP_READ_ZERO = 3'd6;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam logic [COL_W-1:0] PTR_COL_RST = 7'd40;
  localparam logic [ROW_W-1:0] PTR_ROW_RST = 5'd12;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        char_code;
    logic signed [7:0] move_dx;
    logic signed [7:0] move_dy;
    logic [COL_W-1:0]  read_column;
    logic [ROW_W-1:0]  read_row;
  } tcp_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  pointer_column;
    logic [ROW_W-1:0]  pointer_row;
  } tcp_out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        char_code;
    logic signed [7:0] move_dx;
    logic signed [7:0] move_dy;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W-1:0]  rd_row;
  } tcp_cmd_t;

  typedef struct packed {
    logic init_busy;
  } tcp_stat_t;

endpackage

FILE: hw/rtl/text_console_with_pointer_core.sv
// Top level of the text console core: request decode queue plus sequencer.
// Depends on tcp_pkg, tcp_front, tcp_back and the assertion macro header.
//
// Requests arrive on the in_ channel (in_valid, in_stall, in_data) and each
// one produces exactly one transfer on the out_ channel with the cell read
// (zero for other requests) and the cursor and pointer positions after it.
// A transfer happens when valid is high and stall is low.
// Steps: a code zero, a newline without scroll or a read out of range go
// straight to the result; a read waits on the registered read port; a print
// reads and writes the cell at the cursor; a pointer move reads and writes
// the cell under the old pointer, then the cell under the new one. A clear
// walks every cell with a read and a write; a scroll caused by a print or a
// newline copies each cell up one row with a read and a write, then zeroes
// the last row, as the cell memory has a single read and a single write port.
// Requests are carried out one at a time.
// A two-entry queue lets the input side accept requests while the sequencer
// works or a result waits; when it is full, in_stall is raised.
// After reset the memory is swept to zero, one cell per cycle, and no request
// is accepted until the sweep ends.
// When the receiver stalls, the result is held and the sequencer waits.
`include "text_console_with_pointer_core_macros.svh"
module text_console_with_pointer_core import tcp_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tcp_out_t out_data
);

  tcp_stat_t stat;
  tcp_cmd_t  cmd;
  logic      cmd_valid;
  logic      cmd_pop;

  tcp_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .stat     (stat),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  tcp_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The reset sweep runs once; it never restarts without a reset.
  `TCP_ASSERT(a_init_once, clk, rst_n, !stat.init_busy |=> !stat.init_busy, "sweep restarted")
  `TCP_ASSERT(a_no_out_in_init, clk, rst_n, stat.init_busy |-> !out_valid, "result during sweep")
  `TCP_ASSERT(a_pos_range, clk, rst_n, out_valid |-> ({1'b0, out_data.cursor_row} < (ROW_W+1)'(SCREEN_ROWS) && {1'b0, out_data.pointer_row} < (ROW_W+1)'(SCREEN_ROWS) && {1'b0, out_data.cursor_column} < (COL_W+1)'(SCREEN_COLUMNS) && {1'b0, out_data.pointer_column} < (COL_W+1)'(SCREEN_COLUMNS)), "position off screen")

endmodule

FILE: hw/rtl/tcp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/tcp_front.sv
// Front end: accepts requests, decodes them into commands and queues them.
// Depends on tcp_pkg.
module tcp_front import tcp_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tcp_in_t   in_data,
  input  tcp_stat_t stat,
  output logic      cmd_valid,
  output tcp_cmd_t  cmd,
  input  logic      cmd_pop
);

  localparam logic [COL_W:0] COLS_X = (COL_W+1)'(SCREEN_COLUMNS);
  localparam logic [ROW_W:0] ROWS_X = (ROW_W+1)'(SCREEN_ROWS);

  tcp_cmd_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  tcp_cmd_t   dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.char_code = in_data.char_code;
    dec.move_dx   = in_data.move_dx;
    dec.move_dy   = in_data.move_dy;
    dec.rd_col    = in_data.read_column;
    dec.rd_row    = in_data.read_row;
    case (in_data.req_type)
      REQ_PRINT: begin
        if (in_data.char_code == CHAR_NUL) begin
          dec.op = OP_NOP;
        end else if (in_data.char_code == CHAR_NEWLINE) begin
          dec.op = OP_NEWLINE;
        end else begin
          dec.op = OP_PRINT;
        end
      end
      REQ_MOVE:  dec.op = OP_MOVE;
      REQ_CLEAR: dec.op = OP_CLEAR;
      REQ_READ: begin
        if ({1'b0, in_data.read_column} < COLS_X && {1'b0, in_data.read_row} < ROWS_X) begin
          dec.op = OP_READ;
        end else begin
          dec.op = OP_READ_ZERO;
        end
      end
      default: dec.op = OP_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2) || stat.init_busy;
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && (cnt_r != 2'd0);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: hw/rtl/tcp_back.sv
// Back end: sequencer that carries out queued commands on the cell store.
// Depends on tcp_pkg and tcp_ram.
module tcp_back import tcp_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  tcp_cmd_t  cmd,
  output logic      cmd_pop,
  output tcp_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output tcp_out_t  out_data
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE  = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);

  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_PR_RD   = 4'd2;
  localparam logic [3:0] ST_PR_WR   = 4'd3;
  localparam logic [3:0] ST_MV_RD1  = 4'd4;
  localparam logic [3:0] ST_MV_WR1  = 4'd5;
  localparam logic [3:0] ST_MV_RD2  = 4'd6;
  localparam logic [3:0] ST_MV_WR2  = 4'd7;
  localparam logic [3:0] ST_SC_RD   = 4'd8;
  localparam logic [3:0] ST_SC_WR   = 4'd9;
  localparam logic [3:0] ST_SC_ZERO = 4'd10;
  localparam logic [3:0] ST_CL_RD   = 4'd11;
  localparam logic [3:0] ST_CL_WR   = 4'd12;
  localparam logic [3:0] ST_RC_WAIT = 4'd13;
  localparam logic [3:0] ST_EMIT    = 4'd14;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  ptr_col_r, ptr_col_nxt;
  logic [ROW_W-1:0]  ptr_row_r, ptr_row_nxt;
  tcp_cmd_t          cmd_r, cmd_nxt;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcp_out_t          out_data_r, out_data_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] ptr_addr;
  logic [ADDR_W-1:0] cmd_addr;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    logic [ADDR_W-1:0] prod;
    prod = ADDR_W'(row) * COLS_A;
    return prod + ADDR_W'(col);
  endfunction

  function automatic logic [CELL_W-1:0] swap_attr(logic [CELL_W-1:0] v);
    return {v[11:8], v[15:12], v[7:0]};
  endfunction

  function automatic logic [COL_W-1:0] clamp_add(logic [COL_W-1:0] pos,
                                                logic signed [7:0] off,
                                                logic [COL_W:0] limit);
    logic signed [9:0] sum;
    sum = $signed({3'b000, pos}) + $signed({{2{off[7]}}, off});
    if (sum < 10'sd0) begin
      return '0;
    end else if (sum >= $signed({2'b00, limit})) begin
      return COL_W'(limit - 1'b1);
    end else begin
      return COL_W'(sum);
    end
  endfunction

  assign cur_addr = cell_addr(cur_col_r, cur_row_r);
  assign ptr_addr = cell_addr(ptr_col_r, ptr_row_r);
  assign cmd_addr = cell_addr(cmd.rd_col, cmd.rd_row);

  tcp_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    ptr_col_nxt   = ptr_col_r;
    ptr_row_nxt   = ptr_row_r;
    cmd_nxt       = cmd_r;
    cell_nxt      = cell_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = '0;
    rd_addr       = idx_r;

    case (state_r)
      ST_INIT: begin
        wr_en = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_A) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = cmd_addr;
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          cell_nxt = '0;
          case (cmd.op)
            OP_PRINT: state_nxt = ST_PR_RD;
            OP_NEWLINE: begin
              cur_col_nxt = '0;
              if (cur_row_r == LAST_ROW) begin
                idx_nxt   = '0;
                state_nxt = ST_SC_RD;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
                state_nxt   = ST_EMIT;
              end
            end
            OP_MOVE: state_nxt = ST_MV_RD1;
            OP_CLEAR: begin
              idx_nxt   = '0;
              state_nxt = ST_CL_RD;
            end
            OP_READ: state_nxt = ST_RC_WAIT;
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_PR_RD: begin
        rd_addr   = cur_addr;
        state_nxt = ST_PR_WR;
      end
      ST_PR_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {rd_data[15:8], cmd_r.char_code};
        if (cur_col_r == LAST_COL) begin
          cur_col_nxt = '0;
          if (cur_row_r == LAST_ROW) begin
            idx_nxt   = '0;
            state_nxt = ST_SC_RD;
          end else begin
            cur_row_nxt = cur_row_r + 1'b1;
            state_nxt   = ST_EMIT;
          end
        end else begin
          cur_col_nxt = cur_col_r + 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_MV_RD1: begin
        rd_addr   = ptr_addr;
        state_nxt = ST_MV_WR1;
      end
      ST_MV_WR1: begin
        wr_en       = 1'b1;
        wr_addr     = ptr_addr;
        wr_data     = swap_attr(rd_data);
        ptr_col_nxt = clamp_add(ptr_col_r, cmd_r.move_dx, (COL_W+1)'(SCREEN_COLUMNS));
        ptr_row_nxt = ROW_W'(clamp_add(COL_W'(ptr_row_r), cmd_r.move_dy,
                                       (COL_W+1)'(SCREEN_ROWS)));
        state_nxt   = ST_MV_RD2;
      end
      ST_MV_RD2: begin
        rd_addr   = ptr_addr;
        state_nxt = ST_MV_WR2;
      end
      ST_MV_WR2: begin
        wr_en     = 1'b1;
        wr_addr   = ptr_addr;
        wr_data   = swap_attr(rd_data);
        state_nxt = ST_EMIT;
      end
      ST_SC_RD: begin
        rd_addr   = idx_r + COLS_A;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_MOVE) begin
          state_nxt = ST_SC_ZERO;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SC_ZERO: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_A) begin
          idx_nxt     = '0;
          cur_col_nxt = '0;
          cur_row_nxt = LAST_ROW;
          state_nxt   = ST_EMIT;
        end
      end
      ST_CL_RD: begin
        state_nxt = ST_CL_WR;
      end
      ST_CL_WR: begin
        wr_en   = 1'b1;
        wr_data = {rd_data[15:8], CHAR_SPACE};
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_A) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_CL_RD;
        end
      end
      ST_RC_WAIT: begin
        cell_nxt  = rd_data;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.cell_value     = cell_r;
          out_data_nxt.cursor_column  = cur_col_r;
          out_data_nxt.cursor_row     = cur_row_r;
          out_data_nxt.pointer_column = ptr_col_r;
          out_data_nxt.pointer_row    = ptr_row_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      ptr_col_r   <= PTR_COL_RST;
      ptr_row_r   <= PTR_ROW_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      ptr_col_r   <= ptr_col_nxt;
      ptr_row_r   <= ptr_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.init_busy = (state_r == ST_INIT);
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

FILE: test/text_console_with_pointer_core_tb.sv
// Self-checking testbench for text_console_with_pointer_core: directed and random requests
// under several idle and stall patterns, checked against a cycle-free console model.
// Depends on tcp_pkg and the core RTL.
`timescale 1ns / 100ps

module text_console_with_pointer_core_tb;
  import tcp_pkg::*;

  localparam int COLS = DEF_SCREEN_COLUMNS;
  localparam int ROWS = DEF_SCREEN_ROWS;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 50;
  localparam int PRINT_CAP = 100;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tcp_in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  tcp_out_t out_data;

  logic [15:0] screen_model [0:CELL_COUNT-1];
  int cur_col;
  int cur_row;
  int ptr_col;
  int ptr_row;
  tcp_out_t predicted_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  text_console_with_pointer_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    tcp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_data), 0);
      end else begin
        want = predicted_results.pop_front();
        if (out_data.cell_value !== want.cell_value)
          report_mismatch("cell_value", 32'(out_data.cell_value), 32'(want.cell_value));
        if (out_data.cursor_column !== want.cursor_column)
          report_mismatch("cursor_column", 32'(out_data.cursor_column),
                          32'(want.cursor_column));
        if (out_data.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
        if (out_data.pointer_column !== want.pointer_column)
          report_mismatch("pointer_column", 32'(out_data.pointer_column),
                          32'(want.pointer_column));
        if (out_data.pointer_row !== want.pointer_row)
          report_mismatch("pointer_row", 32'(out_data.pointer_row), 32'(want.pointer_row));
      end
    end
  end

  function automatic void flip_attr(int col, int row);
    logic [15:0] v;
    v = screen_model[row * COLS + col];
    screen_model[row * COLS + col] = {v[11:8], v[15:12], v[7:0]};
  endfunction

  function automatic int clamp_step(int pos, logic signed [7:0] offset, int limit);
    int sum;
    sum = pos + int'(offset);
    if (sum >= limit) sum = limit - 1;
    if (sum < 0) sum = 0;
    return sum;
  endfunction

  function automatic tcp_out_t apply_request(tcp_in_t req);
    tcp_out_t res;
    res = '0;
    case (req.req_type)
      REQ_PRINT: begin
        if (req.char_code != CHAR_NUL) begin
          if (req.char_code == CHAR_NEWLINE) begin
            cur_col = 0;
            cur_row++;
          end else begin
            screen_model[cur_row * COLS + cur_col][7:0] = req.char_code;
            cur_col++;
          end
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
          if (cur_row >= ROWS) begin
            for (int i = 0; i < CELL_COUNT; i++)
              screen_model[i] = (i + COLS < CELL_COUNT) ? screen_model[i + COLS] : 16'h0000;
            cur_row = ROWS - 1;
            cur_col = 0;
          end
        end
      end
      REQ_MOVE: begin
        flip_attr(ptr_col, ptr_row);
        ptr_col = clamp_step(ptr_col, req.move_dx, COLS);
        ptr_row = clamp_step(ptr_row, req.move_dy, ROWS);
        flip_attr(ptr_col, ptr_row);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_model[i][7:0] = CHAR_SPACE;
      end
      default: begin
        if (req.read_column < COLS && req.read_row < ROWS)
          res.cell_value = screen_model[req.read_row * COLS + req.read_column];
      end
    endcase
    res.cursor_column = COL_W'(cur_col);
    res.cursor_row = ROW_W'(cur_row);
    res.pointer_column = COL_W'(ptr_col);
    res.pointer_row = ROW_W'(ptr_row);
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge with nothing scheduled there.
  task automatic send_request(tcp_in_t req);
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted_results.push_back(apply_request(req));
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic tcp_in_t random_request();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(tcp_in_t)-1:0];
  endfunction

  function automatic tcp_in_t make_request(logic [1:0] kind, logic [7:0] code,
                                           logic signed [7:0] dx, logic signed [7:0] dy,
                                           int col, int row);
    tcp_in_t req;
    req = random_request();
    req.req_type = kind;
    req.char_code = code;
    req.move_dx = dx;
    req.move_dy = dy;
    req.read_column = COL_W'(col);
    req.read_row = ROW_W'(row);
    return req;
  endfunction

  task automatic set_idling(int sender_pct, int receiver_pct);
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  task automatic test_edge_cases();
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, COLS - 1, ROWS - 1));
    send_request(make_request(REQ_READ, 8'hFF, 8'sd0, 8'sd0, COLS, 0));
    send_request(make_request(REQ_READ, 8'hFF, 8'sd0, 8'sd0, 0, ROWS));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, 127, 31));
    send_request(make_request(REQ_PRINT, CHAR_NUL, -8'sd1, -8'sd1, 127, 31));
    send_request(make_request(REQ_PRINT, 8'h41, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_PRINT, 8'hFF, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_PRINT, CHAR_NEWLINE, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_PRINT, 8'h01, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_MOVE, 8'h00, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_MOVE, 8'h00, 8'sd127, 8'sd127, 0, 0));
    send_request(make_request(REQ_MOVE, 8'h00, -8'sd128, -8'sd128, 0, 0));
    send_request(make_request(REQ_MOVE, 8'h00, 8'sd3, -8'sd1, 0, 0));
    send_request(make_request(REQ_MOVE, 8'hFF, -8'sd128, 8'sd127, 0, 0));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, ptr_col, ptr_row));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, 1, 0));
    send_request(make_request(REQ_CLEAR, 8'hFF, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, 0, 1));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, COLS - 1, ROWS - 1));
    send_request(make_request(REQ_PRINT, 8'h5A, 8'sd0, 8'sd0, 0, 0));
    send_request(make_request(REQ_READ, 8'h00, 8'sd0, 8'sd0, 1, 1));
  endtask

  task automatic test_pointer_moves(int count);
    tcp_in_t req;
    repeat (count) begin
      req = random_request();
      req.req_type = REQ_MOVE;
      case ($urandom_range(4))
        0, 1: begin
          req.move_dx = 8'(int'($urandom_range(4)) - 2);
          req.move_dy = 8'(int'($urandom_range(4)) - 2);
        end
        2: ;
        3: begin
          req.move_dx = $urandom_range(1) ? 8'sd127 : -8'sd128;
          req.move_dy = $urandom_range(1) ? 8'sd127 : -8'sd128;
        end
        default: begin
          req.req_type = REQ_READ;
          req.read_column = COL_W'(ptr_col);
          req.read_row = ROW_W'(ptr_row);
        end
      endcase
      send_request(req);
    end
  endtask

  // Short lines of text with newlines and read-backs, so the cursor wraps and scrolls often.
  task automatic test_text_scroll(int count);
    tcp_in_t req;
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(82, 78) : $urandom_range(8);
      for (int k = 0; k < len; k++) begin
        req = random_request();
        req.req_type = REQ_PRINT;
        send_request(req);
        sent++;
      end
      if ($urandom_range(4) != 0) begin
        req = random_request();
        req.req_type = REQ_PRINT;
        req.char_code = CHAR_NEWLINE;
        send_request(req);
        sent++;
      end
      if ($urandom_range(2) == 0) begin
        req = random_request();
        req.req_type = REQ_READ;
        req.read_column = COL_W'($urandom_range(COLS - 1));
        req.read_row = ROW_W'($urandom_range(ROWS - 1));
        send_request(req);
        sent++;
      end
    end
  endtask

  task automatic test_random_mix(int count);
    tcp_in_t req;
    int pick;
    repeat (count) begin
      req = random_request();
      pick = $urandom_range(99);
      if (pick < 50) begin
        req.req_type = REQ_PRINT;
        if ($urandom_range(11) == 0) req.char_code = CHAR_NEWLINE;
        else if ($urandom_range(29) == 0) req.char_code = CHAR_NUL;
      end else if (pick < 70) begin
        req.req_type = REQ_MOVE;
      end else if (pick < 71) begin
        req.req_type = REQ_CLEAR;
      end else begin
        req.req_type = REQ_READ;
        if ($urandom_range(9) != 0) begin
          req.read_column = COL_W'($urandom_range(COLS - 1));
          req.read_row = ROW_W'($urandom_range(ROWS - 1));
        end
      end
      send_request(req);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = 16'h0000;
    cur_col = 0;
    cur_row = 0;
    ptr_col = int'(PTR_COL_RST);
    ptr_row = int'(PTR_ROW_RST);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(0, 0);
    test_edge_cases();
    test_random_mix(250);
    set_idling(70, 0);
    test_pointer_moves(250);
    test_random_mix(250);
    set_idling(0, 70);
    test_text_scroll(450);
    test_random_mix(250);
    set_idling(10, 10);
    test_random_mix(250);
    in_valid <= 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
